FILE: rtl/core/priority_wait_queue_assert.svh
// assertion macros of the wait queue rtl, included by pwq_ctrl
`ifndef PRIORITY_WAIT_QUEUE_ASSERT_SVH
`define PRIORITY_WAIT_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PWQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pwq_pkg.sv
// types, constants and helpers of the priority wait queue
package pwq_pkg;

    localparam int MAX_WAITERS = 16;
    localparam int IDX_W = $clog2(MAX_WAITERS);
    localparam int CNT_W = $clog2(MAX_WAITERS + 1);
    localparam int ENTRY_W = 16;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_FIRST  = 2'd1,
        MODE_TASK   = 2'd2,
        MODE_ALL    = 2'd3
    } pwq_mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } pwq_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_PUT,
        S_RM_RD,
        S_RM_CHK,
        S_DRN_RD,
        S_DRN_CHK,
        S_RESP
    } pwq_state_t;

    typedef struct packed {
        pwq_mode_t   mode;
        logic [7:0]  task_id;
        logic [7:0]  task_prio;
        logic [7:0]  wake_code;
        logic [31:0] wake_tag;
    } pwq_in_t;

    typedef struct packed {
        logic [7:0]  woken_id;
        logic [7:0]  woken_code;
        logic [31:0] woken_tag;
        pwq_status_t status;
        logic [4:0]  waiters;
        logic        last;
    } pwq_out_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] prio;
    } pwq_entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        pwq_entry_t       wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } pwq_mem_req_t;

    typedef struct packed {
        logic     load;
        pwq_out_t data;
    } pwq_res_t;

    // waiter count as the 5-bit field, wrapping for deep queues
    function automatic logic [4:0] to_waiters(input logic [CNT_W-1:0] c);
        logic [CNT_W+4:0] t;
        t = {5'b0, c};
        return t[4:0];
    endfunction

endpackage

FILE: rtl/core/pwq_ram.sv
// generic single-write single-read ram with registered read data
module pwq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/pwq_ctrl.sv
// sequencer that walks the sorted list in ram one entry per step
module pwq_ctrl
    import pwq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  pwq_in_t      in_data,
    output logic         in_stall,
    input  logic         out_free,
    input  pwq_entry_t   rd_data,
    output pwq_mem_req_t mem,
    output pwq_res_t     res
);

    `include "priority_wait_queue_assert.svh"

    pwq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             found_reg, found_next;
    pwq_in_t          req_reg, req_next;
    logic [7:0]       woken_reg, woken_next;
    pwq_out_t         pend_reg, pend_next;

    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] idx_ext;
    logic             at_tail;
    logic             hit;
    pwq_entry_t       new_entry;

    assign cnt_m1    = cnt_reg - 1'b1;
    assign idx_ext   = CNT_W'(idx_reg);
    assign at_tail   = (idx_ext == cnt_m1);
    assign new_entry = '{id: req_reg.task_id, prio: req_reg.task_prio};
    assign in_stall  = (state_reg != S_IDLE);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        woken_reg <= woken_next;
        pend_reg  <= pend_next;
    end

    // next state, memory accesses and results
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        req_next   = req_reg;
        woken_next = woken_reg;
        pend_next  = pend_reg;
        mem        = '0;
        res        = '0;
        hit        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                pend_next = '0;
                pend_next.last = 1'b1;
                found_next = 1'b0;
                idx_next = '0;
                if (in_valid)
                begin
                    req_next = in_data;
                    unique case (in_data.mode)
                        MODE_WAIT:
                        begin
                            if (cnt_reg >= CNT_W'(MAX_WAITERS))
                            begin
                                pend_next.status = ST_FULL;
                                state_next = S_RESP;
                            end
                            else if (cnt_reg == '0)
                            begin
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                idx_next = cnt_m1[IDX_W-1:0];
                                state_next = S_INS_RD;
                            end
                        end
                        MODE_FIRST, MODE_TASK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pend_next.status = (in_data.mode == MODE_FIRST) ?
                                                   ST_EMPTY : ST_NOTFOUND;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_RM_RD;
                            end
                        end
                        MODE_ALL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pend_next.status = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_DRN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // insert: walk from the tail, moving lower priorities one down
            S_INS_RD:
            begin
                mem.rd_en = 1'b1;
                mem.rd_addr = idx_reg;
                state_next = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                mem.wr_en = 1'b1;
                mem.wr_addr = idx_reg + 1'b1;
                if (rd_data.prio < req_reg.task_prio)
                begin
                    mem.wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    mem.wr_data = new_entry;
                    cnt_next = cnt_reg + 1'b1;
                    state_next = S_RESP;
                end
            end
            S_INS_PUT:
            begin
                mem.wr_en = 1'b1;
                mem.wr_addr = idx_reg;
                mem.wr_data = new_entry;
                cnt_next = cnt_reg + 1'b1;
                state_next = S_RESP;
            end

            // remove: find the entry, then pull the rest up by one
            S_RM_RD:
            begin
                mem.rd_en = 1'b1;
                mem.rd_addr = idx_reg;
                state_next = S_RM_CHK;
            end
            S_RM_CHK:
            begin
                if (found_reg)
                begin
                    mem.wr_en = 1'b1;
                    mem.wr_addr = idx_reg - 1'b1;
                    mem.wr_data = rd_data;
                end
                else
                begin
                    hit = (req_reg.mode == MODE_FIRST) || (rd_data.id == req_reg.task_id);
                end
                if (hit)
                begin
                    found_next = 1'b1;
                    woken_next = rd_data.id;
                end
                if (at_tail)
                begin
                    if (found_reg || hit)
                    begin
                        cnt_next = cnt_m1;
                        pend_next.woken_id = hit ? rd_data.id : woken_reg;
                        if (req_reg.mode == MODE_TASK)
                        begin
                            pend_next.woken_code = req_reg.wake_code;
                            pend_next.woken_tag = req_reg.wake_tag;
                        end
                    end
                    else
                    begin
                        pend_next.status = ST_NOTFOUND;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_RM_RD;
                end
            end

            // drain: one result per entry in queue order
            S_DRN_RD:
            begin
                mem.rd_en = 1'b1;
                mem.rd_addr = idx_reg;
                state_next = S_DRN_CHK;
            end
            S_DRN_CHK:
            begin
                if (out_free)
                begin
                    res.load = 1'b1;
                    res.data.woken_id = rd_data.id;
                    res.data.woken_code = req_reg.wake_code;
                    res.data.woken_tag = req_reg.wake_tag;
                    res.data.status = ST_OK;
                    res.data.waiters = to_waiters(cnt_m1 - idx_ext);
                    res.data.last = at_tail;
                    if (at_tail)
                    begin
                        cnt_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_DRN_RD;
                    end
                end
            end

            // single result once the output register is free
            S_RESP:
            begin
                if (out_free)
                begin
                    res.load = 1'b1;
                    res.data = pend_reg;
                    res.data.waiters = to_waiters(cnt_reg);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `PWQ_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(MAX_WAITERS), "waiter count overflow")
    `PWQ_ASSERT_IMPL(a_load_free, res.load, out_free, "result loaded into busy output")
    `PWQ_ASSERT_NEXT(a_drain_empty, (state_reg == S_DRN_CHK) && res.load && res.data.last, cnt_reg == '0, "drain left waiters")
    `PWQ_ASSERT_IMPL(a_rw_apart, mem.wr_en && mem.rd_en, 1'b0, "read and write in one step")

endmodule

FILE: rtl/core/priority_wait_queue.sv
// Priority wait queue: ordered list of waiting tasks, highest priority first.
// Input channel in_valid/in_stall/in_data carries one request per beat:
// insert a waiter, wake the head, wake a named task, or drain all waiters.
// Output channel out_valid/out_stall/out_data returns the result beats; a
// drain gives one beat per waiter, with last set on the final one.
// The list lives in a single ram; the sequencer visits one entry at a time
// (read, then check and write back), and a drain gives a result beat per entry.
// Rejected requests (full, empty) go straight to the response; a named task
// that is not waiting is only known after the whole list is walked.
// One request is worked at a time; in_stall is high until its last result
// sits in the output register, which then holds while out_stall is high.
// A stalled receiver holds up the sequencer only when a new beat is ready.
// Reset empties the list at once (count to zero); no clearing pass is needed.
module priority_wait_queue
    import pwq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  pwq_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output pwq_out_t out_data
);

    pwq_mem_req_t mem;
    pwq_res_t     res;
    pwq_entry_t   rd_data;
    logic         out_free;
    logic         out_valid_reg;
    pwq_out_t     out_data_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    pwq_ram #(
        .DEPTH (MAX_WAITERS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_data),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_data)
    );

    pwq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .out_free (out_free),
        .rd_data  (rd_data),
        .mem      (mem),
        .res      (res)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res.load;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            out_data_reg <= res.data;
        end
    end

endmodule

FILE: bench/testbench.sv
// self-checking testbench of the priority wait queue
`timescale 1ns / 1ps

module testbench;
    import pwq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    pwq_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    pwq_out_t out_data;

    // shadow of the waiting list, head at index 0
    logic [7:0] shadow_ids[$];
    logic [7:0] shadow_prios[$];
    pwq_out_t   expected_beats[$];

    int  mismatches;
    int  idle_cycles;
    bit  hold_receiver;
    bit  timed_out;

    priority_wait_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic pwq_out_t make_beat(logic [7:0] id, logic [7:0] code,
                                           logic [31:0] tag, pwq_status_t st,
                                           bit fin);
        pwq_out_t b;
        b.woken_id   = id;
        b.woken_code = code;
        b.woken_tag  = tag;
        b.status     = st;
        b.waiters    = 5'(shadow_ids.size());
        b.last       = fin;
        return b;
    endfunction

    // update the shadow list and queue the beats one request causes
    function automatic void predict_wakeups(pwq_in_t req);
        int pos;
        logic [7:0] w;
        case (req.mode)
            MODE_WAIT:
            begin
                if (shadow_ids.size() >= MAX_WAITERS)
                    expected_beats.push_back(make_beat(0, 0, 0, ST_FULL, 1));
                else
                begin
                    pos = shadow_ids.size();
                    for (int i = 0; i < shadow_ids.size(); i++)
                        if (shadow_prios[i] < req.task_prio)
                        begin
                            pos = i;
                            break;
                        end
                    shadow_ids.insert(pos, req.task_id);
                    shadow_prios.insert(pos, req.task_prio);
                    expected_beats.push_back(make_beat(0, 0, 0, ST_OK, 1));
                end
            end
            MODE_FIRST:
            begin
                if (shadow_ids.size() == 0)
                    expected_beats.push_back(make_beat(0, 0, 0, ST_EMPTY, 1));
                else
                begin
                    w = shadow_ids.pop_front();
                    void'(shadow_prios.pop_front());
                    expected_beats.push_back(make_beat(w, 0, 0, ST_OK, 1));
                end
            end
            MODE_TASK:
            begin
                pos = -1;
                for (int i = 0; i < shadow_ids.size(); i++)
                    if (shadow_ids[i] == req.task_id)
                    begin
                        pos = i;
                        break;
                    end
                if (pos < 0)
                    expected_beats.push_back(make_beat(0, 0, 0, ST_NOTFOUND, 1));
                else
                begin
                    shadow_ids.delete(pos);
                    shadow_prios.delete(pos);
                    expected_beats.push_back(make_beat(req.task_id, req.wake_code,
                                                       req.wake_tag, ST_OK, 1));
                end
            end
            default:
            begin
                if (shadow_ids.size() == 0)
                    expected_beats.push_back(make_beat(0, 0, 0, ST_EMPTY, 1));
                while (shadow_ids.size() > 0)
                begin
                    w = shadow_ids.pop_front();
                    void'(shadow_prios.pop_front());
                    expected_beats.push_back(make_beat(w, req.wake_code, req.wake_tag,
                                                       ST_OK, shadow_ids.size() == 0));
                end
            end
        endcase
    endfunction

    // send one request beat, predicting on acceptance; valid stays high
    // for a back-to-back follower and drops at the next gap or pause
    task automatic send_request(pwq_mode_t m, logic [7:0] id, logic [7:0] prio,
                                logic [7:0] code, logic [31:0] tag);
        pwq_in_t req;
        int gap;
        req.mode      = m;
        req.task_id   = id;
        req.task_prio = prio;
        req.wake_code = code;
        req.wake_tag  = tag;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_wakeups(req);
    endtask

    task automatic send_random(int pct_wait);
        int r;
        r = $urandom_range(0, 99);
        if (r < pct_wait)
            send_request(MODE_WAIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom), $urandom);
        else if (r < pct_wait + 12)
            send_request(MODE_FIRST, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom), $urandom);
        else if (r < pct_wait + 27 && shadow_ids.size() > 0 && $urandom_range(0, 3) != 0)
            send_request(MODE_TASK, shadow_ids[$urandom_range(0, shadow_ids.size() - 1)],
                         8'($urandom), 8'($urandom), $urandom);
        else if (r < pct_wait + 27)
            send_request(MODE_TASK, 8'($urandom_range(0, 255)), 8'($urandom),
                         8'($urandom), $urandom);
        else
            send_request(MODE_ALL, 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
    endtask

    // stop offering and wait for every expected beat
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() > 0)
            @(posedge clk);
    endtask

    // edges of every field, every mode and each special case
    task automatic test_directed();
        send_request(MODE_FIRST, 8'h00, 8'h00, 8'hFF, 32'hFFFF_FFFF);
        send_request(MODE_ALL, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(MODE_TASK, 8'h12, 8'h00, 8'h55, 32'h1234_5678);
        send_request(MODE_WAIT, 8'h00, 8'h00, 8'h00, 32'h0);
        send_request(MODE_WAIT, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(MODE_WAIT, 8'h21, 8'h80, 8'h00, 32'h0);
        send_request(MODE_WAIT, 8'h22, 8'h80, 8'h00, 32'h0);
        send_request(MODE_WAIT, 8'h21, 8'h80, 8'h00, 32'h0);
        send_request(MODE_TASK, 8'h21, 8'h00, 8'hAA, 32'hDEAD_BEEF);
        send_request(MODE_TASK, 8'h77, 8'h00, 8'hAA, 32'hDEAD_BEEF);
        send_request(MODE_FIRST, 8'h00, 8'h00, 8'hFF, 32'hFFFF_FFFF);
        send_request(MODE_ALL, 8'h00, 8'h00, 8'hFF, 32'hFFFF_FFFF);
        // fill to capacity, then one insert too many
        for (int i = 0; i < MAX_WAITERS + 1; i++)
            send_request(MODE_WAIT, 8'(i), 8'(i % 4), 8'h00, 32'h0);
        send_request(MODE_ALL, 8'h00, 8'h00, 8'hA5, 32'h5A5A_A5A5);
    endtask

    // long receiver hold while the sender keeps offering
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_receiver = 1'b0;
            end
            for (int i = 0; i < 10; i++)
                send_random(60);
        join
        wait_drained();
    endtask

    task automatic test_random();
        for (int i = 0; i < 180; i++)
        begin
            send_random(shadow_ids.size() < 4 ? 70 : 45);
            if (i == 90)
                wait_drained();
        end
    endtask

    // receiver stall generator
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
                out_stall <= 1'b1;
            else
            begin
                gap = pick_gap();
                out_stall <= (gap > 0);
                if (gap > 0)
                    repeat (gap - 1) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        pwq_out_t exp_beat;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %p", out_data);
            end
            else
            begin
                exp_beat = expected_beats.pop_front();
                if (out_data !== exp_beat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_beat, out_data);
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
            timed_out = 1'b1;
    end

    initial
    begin
        mismatches    = 0;
        idle_cycles   = 0;
        hold_receiver = 1'b0;
        timed_out     = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            begin
                test_directed();
                test_backpressure();
                test_random();
                wait_drained();
                repeat (50) @(posedge clk);
            end
            wait (timed_out);
        join_any
        if (timed_out)
            $display("FAILURE");
        else if (mismatches == 0 && expected_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/pwq_pkg.sv
rtl/core/pwq_ram.sv
rtl/core/pwq_ctrl.sv
rtl/core/priority_wait_queue.sv
bench/testbench.sv
